// ===== rtl/core/med3_pkg.sv =====
// ----------------------------------------------------------------------------
// med3_pkg
// Shared types and constants for the 3x3 median filter: channel payloads,
// configuration register indexes, command codes and frame limits.
// ----------------------------------------------------------------------------
package med3_pkg;

  // Command codes carried on the input channel
  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  // Field widths fixed by the channel definitions
  localparam int OUT_PIX_BITS = 8;
  localparam int IN_PIX_BITS  = 8;

  // Configuration register file
  localparam int CFG_INDEX_BITS  = 1;
  localparam int CFG_DATA_BITS   = 13;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int HGT_BITS        = 13;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT = 1'd1;

  // Frame geometry limits and reset values
  localparam int MIN_DIM       = 3;
  localparam int HEIGHT_MAX    = 4096;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;
  localparam int ROW_BITS      = 12;
  localparam int POS_BITS      = 22;

  // 3x3 window
  localparam int WIN_TAPS = 9;
  localparam int MED_TAP  = 4;

  typedef struct packed {
    cmd_t                   command;
    logic [IN_PIX_BITS-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [OUT_PIX_BITS-1:0] pixel_out;
    logic                    frame_last;
  } out_item_t;

  // Per-job control handed from the front end to the median pipeline
  typedef struct packed {
    logic zero;   // border or flush output, value forced to 0
    logic last;   // final output of the frame
  } job_flags_t;

endpackage

// ===== rtl/core/med3_front.sv =====
// ----------------------------------------------------------------------------
// med3_front
// Front end: takes pixel and flush items, tracks the raster position, keeps
// the two line stores and the 3x3 window, and issues one job per output.
// ----------------------------------------------------------------------------
module med3_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          in_valid,
  output logic                                          in_ready,
  input  med3_pkg::in_item_t                            in_data,
  input  logic                                          cfg_wr_en,
  input  logic [med3_pkg::CFG_INDEX_BITS-1:0]           cfg_index,
  input  logic [med3_pkg::CFG_DATA_BITS-1:0]            cfg_data,
  output logic                                          push_valid,
  input  logic                                          push_ready,
  output med3_pkg::job_flags_t                          push_flags,
  output logic [med3_pkg::WIN_TAPS*PIXEL_BITS-1:0]      push_window
);
  import med3_pkg::*;

  localparam int CW      = $clog2(MAX_WIDTH);
  localparam int CW1     = CW + 1;
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int RW_EXT  = (WW > CFG_WIDTH_BITS) ? WW : CFG_WIDTH_BITS;
  localparam int TW      = WW + HGT_BITS;
  localparam int QW      = ROW_BITS + WW + 1;
  localparam int PW      = (TW > POS_BITS) ? TW : POS_BITS;
  localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  typedef logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win_t;

  // Configuration, kept saturated, with the frame size product
  logic [WW-1:0]       width_q;
  logic [HGT_BITS-1:0] height_q;
  logic [TW-1:0]       total_q;
  logic [RW_EXT-1:0]   raw_w;
  logic [HGT_BITS-1:0] raw_h;
  logic [WW-1:0]       new_w;
  logic [HGT_BITS-1:0] new_h;
  logic [WW-1:0]       mul_w;
  logic [HGT_BITS-1:0] mul_h;
  logic [TW-1:0]       total_new;

  // Raster position
  logic [CW-1:0]       col_q;
  logic [ROW_BITS-1:0] row_q;
  logic [POS_BITS-1:0] pos_q;

  // Classification
  logic [QW-1:0]       q;
  logic                pix_emit;
  logic                pix_inner;
  logic [CW1-1:0]      col_inc;
  logic                wrap_col;
  logic [HGT_BITS-1:0] row_inc;
  logic                wrap_row;
  logic                flush_owe;
  logic                flush_last;
  logic                is_pixel;
  logic                acc;

  // Window stage
  logic                  s_valid;
  logic                  s_pixel;
  logic                  s_emit;
  job_flags_t            s_flags;
  logic [PIXEL_BITS-1:0] s_px;
  logic [CW-1:0]         s_col;
  logic                  s_adv;
  logic [PIXEL_BITS-1:0] rd_upper;
  logic [PIXEL_BITS-1:0] rd_middle;
  win_t                  window_q;
  win_t                  win_next;

  // Line stores
  logic [PIXEL_BITS-1:0] line_upper  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] line_middle [MAX_WIDTH];

  // Saturate incoming register values and form the frame size
  always_comb begin
    raw_w = RW_EXT'(cfg_data[CFG_WIDTH_BITS-1:0]);
    raw_h = cfg_data[HGT_BITS-1:0];
    if (raw_w < RW_EXT'(MIN_DIM)) begin
      new_w = WW'(MIN_DIM);
    end else if (raw_w > RW_EXT'(MAX_WIDTH)) begin
      new_w = WW'(MAX_WIDTH);
    end else begin
      new_w = WW'(raw_w);
    end
    if (raw_h < HGT_BITS'(MIN_DIM)) begin
      new_h = HGT_BITS'(MIN_DIM);
    end else if (raw_h > HGT_BITS'(HEIGHT_MAX)) begin
      new_h = HGT_BITS'(HEIGHT_MAX);
    end else begin
      new_h = raw_h;
    end
    mul_w     = (cfg_index == CFG_IMAGE_WIDTH)  ? new_w : width_q;
    mul_h     = (cfg_index == CFG_IMAGE_HEIGHT) ? new_h : height_q;
    total_new = TW'(mul_w) * TW'(mul_h);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= WW'(W_RESET);
      height_q <= HGT_BITS'(HEIGHT_RESET);
      total_q  <= TW'(W_RESET * HEIGHT_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          width_q <= new_w;
          total_q <= total_new;
        end
        CFG_IMAGE_HEIGHT: begin
          height_q <= new_h;
          total_q  <= total_new;
        end
        default: ;
      endcase
    end
  end

  // Classify the item at the input against the current position
  always_comb begin
    is_pixel   = (in_data.command == CMD_PIXEL);
    q          = QW'(row_q) * QW'(width_q) + QW'(col_q);
    pix_emit   = q >= (QW'(width_q) + QW'(1));
    pix_inner  = (col_q >= CW'(2)) && (CW1'(col_q) < CW1'(width_q)) &&
                 (row_q >= ROW_BITS'(2)) && (HGT_BITS'(row_q) < height_q);
    col_inc    = CW1'(col_q) + CW1'(1);
    wrap_col   = col_inc >= CW1'(width_q);
    row_inc    = HGT_BITS'(row_q) + HGT_BITS'(1);
    wrap_row   = row_inc >= height_q;
    flush_owe  = (col_q == '0) && (row_q == '0) && (pos_q != '0) &&
                 (PW'(pos_q) < PW'(total_q));
    flush_last = PW'(pos_q) == (PW'(total_q) - PW'(1));
  end

  assign s_adv    = s_valid && (!s_emit || push_ready);
  assign in_ready = !rst && (!s_valid || s_adv);
  assign acc      = in_valid && in_ready;

  // Position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
    end else if (acc) begin
      case (in_data.command)
        CMD_PIXEL: begin
          if (pix_emit) begin
            pos_q <= POS_BITS'(q - QW'(width_q));
          end
          if (wrap_col) begin
            col_q <= '0;
            row_q <= wrap_row ? '0 : ROW_BITS'(row_inc);
          end else begin
            col_q <= CW'(col_inc);
          end
        end
        CMD_FLUSH: begin
          if (flush_owe) begin
            pos_q <= flush_last ? '0 : pos_q + POS_BITS'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Window stage occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  // Window stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s_pixel       <= is_pixel;
      s_emit        <= is_pixel ? pix_emit : flush_owe;
      s_flags.zero  <= is_pixel ? !pix_inner : 1'b1;
      s_flags.last  <= is_pixel ? 1'b0 : flush_last;
      s_px          <= PIXEL_BITS'(in_data.pixel_in);
      s_col         <= col_q;
    end
  end

  // Line stores: read on transfer in, write back when the pixel moves on
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_upper <= line_upper[col_q];
    end
    if (s_adv && s_pixel) begin
      line_upper[s_col] <= rd_middle;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_middle <= line_middle[col_q];
    end
    if (s_adv && s_pixel) begin
      line_middle[s_col] <= s_px;
    end
  end

  // Window shifts one column left; new right column from stores and input
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[3*k]     = window_q[3*k+1];
      win_next[3*k+1]   = window_q[3*k+2];
    end
    win_next[2] = rd_upper;
    win_next[5] = rd_middle;
    win_next[8] = s_px;
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_pixel) begin
      window_q <= win_next;
    end
  end

  assign push_valid  = s_valid && s_emit;
  assign push_flags  = s_flags;
  assign push_window = win_next;

endmodule

// ===== rtl/core/med3_fifo.sv =====
// ----------------------------------------------------------------------------
// med3_fifo
// Small job queue between the front end and the median pipeline.
// ----------------------------------------------------------------------------
module med3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNTW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNTW'(1);
        2'b01:   count <= count - CNTW'(1);
        default: ;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/core/med3_back.sv =====
// ----------------------------------------------------------------------------
// med3_back
// Back end: three-stage compare-exchange network that picks the median of
// the nine window taps, with the output register.
// ----------------------------------------------------------------------------
module med3_back #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     pop_valid,
  output logic                                     pop_ready,
  input  med3_pkg::job_flags_t                     pop_flags,
  input  logic [med3_pkg::WIN_TAPS*PIXEL_BITS-1:0] pop_window,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output med3_pkg::out_item_t                      out_data
);
  import med3_pkg::*;

  typedef logic [WIN_TAPS-1:0][PIXEL_BITS-1:0] win_t;

  // Compare-exchange: smaller value ends up at position a
  function automatic win_t cx(input win_t v, input logic [3:0] a, input logic [3:0] b);
    win_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  logic       adv;
  logic       v1;
  logic       v2;
  job_flags_t f1;
  job_flags_t f2;
  win_t       st1;
  win_t       st2;
  win_t       a0, a1, a2, a3;
  win_t       b1, b2, b3;
  win_t       c1, c2, c3;

  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv;

  // Network, first third: sort each row triple
  always_comb begin
    a0 = pop_window;
    a1 = cx(cx(cx(a0, 4'd1, 4'd2), 4'd4, 4'd5), 4'd7, 4'd8);
    a2 = cx(cx(cx(a1, 4'd0, 4'd1), 4'd3, 4'd4), 4'd6, 4'd7);
    a3 = cx(cx(cx(a2, 4'd1, 4'd2), 4'd4, 4'd5), 4'd7, 4'd8);
  end

  // Second third: cross-row max of mins, median of middles, min of maxes
  always_comb begin
    b1 = cx(cx(cx(st1, 4'd0, 4'd3), 4'd5, 4'd8), 4'd4, 4'd7);
    b2 = cx(cx(cx(b1, 4'd3, 4'd6), 4'd1, 4'd4), 4'd2, 4'd5);
    b3 = cx(b2, 4'd4, 4'd7);
  end

  // Last third: median settles in the center tap
  always_comb begin
    c1 = cx(st2, 4'd4, 4'd2);
    c2 = cx(c1, 4'd6, 4'd4);
    c3 = cx(c2, 4'd4, 4'd2);
  end

  // Stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= pop_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      st1 <= a3;
      f1  <= pop_flags;
      st2 <= b3;
      f2  <= f1;
      out_data.pixel_out  <= f2.zero ? '0 : OUT_PIX_BITS'(c3[MED_TAP]);
      out_data.frame_last <= f2.last;
    end
  end

endmodule

// ===== rtl/core/median_filter_3x3_top.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_top
// 3x3 median filter over a raster-order grayscale stream with frame border
// zeroing and flush of the trailing border outputs.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid / in_ready    | in_data  {command, pixel_in}
//   out     | output    | out_valid / out_ready  | out_data {pixel_out, frame_last}
//   cfg     | input     | cfg_wr_en              | cfg_index, cfg_data
//
// One item per clock while the output is not stalled; the line stores take one
// read and one write per cycle each, and the median network is split over
// three registers. Synchronous reset clears counters and pipeline valids; the
// line stores are not cleared and need no clearing pass.
// A stall at the output backs up through the median stages and the two-entry
// job queue before the input side stops taking items.
// ----------------------------------------------------------------------------
module median_filter_3x3_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  med3_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output med3_pkg::out_item_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [med3_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [med3_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import med3_pkg::*;

  localparam int WINW  = WIN_TAPS * PIXEL_BITS;
  localparam int JOBW  = $bits(job_flags_t) + WINW;

  logic             push_valid;
  logic             push_ready;
  job_flags_t       push_flags;
  logic [WINW-1:0]  push_window;
  logic             pop_valid;
  logic             pop_ready;
  job_flags_t       pop_flags;
  logic [WINW-1:0]  pop_window;
  logic [JOBW-1:0]  fifo_wr_data;
  logic [JOBW-1:0]  fifo_rd_data;

  // Front end: position tracking, line stores, window
  med3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_flags  (push_flags),
    .push_window (push_window)
  );

  assign fifo_wr_data            = {push_flags, push_window};
  assign {pop_flags, pop_window} = fifo_rd_data;

  // Job queue
  med3_fifo #(
    .WIDTH (JOBW),
    .DEPTH (2)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (fifo_wr_data),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (fifo_rd_data)
  );

  // Back end: median network and output register
  med3_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_flags  (pop_flags),
    .pop_window (pop_window),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== bench/median_filter_3x3_top_tb.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_top_tb
// Self-checking bench for the 3x3 median filter. A behavioral predictor of
// the line stores, the 3x3 window and the raster counters works out every
// output pixel as input transfers are accepted. A checker compares each
// output transfer with the oldest predicted pixel. Directed tests cover the
// reset geometry, value and tie corners, register saturation and mid-frame
// geometry changes. Random frames follow, with noise and truncated flushes,
// under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module median_filter_3x3_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import med3_pkg::*;

  localparam int unsigned LINE_DEPTH   = 1024;
  localparam int unsigned IDLE_SETTLE  = 20;
  localparam int unsigned END_WAIT_MAX = 100000;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  in_item_t                  in_data;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Predictor state
  logic [CFG_WIDTH_BITS-1:0] geo_width  = CFG_WIDTH_BITS'(WIDTH_RESET);
  logic [HGT_BITS-1:0]       geo_height = HGT_BITS'(HEIGHT_RESET);
  logic [7:0]                prev_row_top [LINE_DEPTH] = '{default: '0};
  logic [7:0]                prev_row_mid [LINE_DEPTH] = '{default: '0};
  logic [7:0]                window_px [WIN_TAPS] = '{default: '0};
  int unsigned               x_pos = 0;
  int unsigned               y_pos = 0;
  logic [POS_BITS-1:0]       emit_pos = '0;
  out_item_t                 pending_outputs [$];

  // Run control and bookkeeping
  int unsigned send_idle_pct = 14;
  int unsigned recv_idle_pct = 58;
  int unsigned stall_request = 0;
  int unsigned hold_left     = 0;
  int unsigned err_count     = 0;
  int unsigned items_sent    = 0;
  int unsigned results_checked = 0;
  int unsigned frame_ends    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned stall_cycles  = 0;
  out_item_t   head_want;

  median_filter_3x3_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int unsigned frame_width();
    int unsigned w;
    w = geo_width;
    if (w < MIN_DIM) w = MIN_DIM;
    else if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned frame_height();
    int unsigned h;
    h = geo_height;
    if (h < MIN_DIM) h = MIN_DIM;
    else if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    return h;
  endfunction

  // insertion sort of the window, middle entry
  function automatic logic [7:0] median_of_window();
    logic [7:0] s [WIN_TAPS];
    logic [7:0] t;
    int i, j;
    for (i = 0; i < WIN_TAPS; i++) s[i] = window_px[i];
    for (i = 1; i < WIN_TAPS; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] > t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return s[MED_TAP];
  endfunction

  // trailing border outputs still owed for the frame just ended
  function automatic bit flush_owed();
    return x_pos == 0 && y_pos == 0 && emit_pos != 0 &&
           emit_pos < frame_width() * frame_height();
  endfunction

  task automatic model_item(input in_item_t item);
    int unsigned w, h, c, r, q, orow, ocol, slot, total;
    int k;
    out_item_t res;
    w = frame_width();
    h = frame_height();
    c = x_pos;
    r = y_pos;
    total = w * h;
    if (item.command == CMD_FLUSH) begin
      if (flush_owed()) begin
        res.pixel_out  = '0;
        res.frame_last = (emit_pos == total - 1);
        pending_outputs.push_back(res);
        emit_pos = res.frame_last ? '0 : emit_pos + 1'b1;
      end
    end else begin
      // shift window left, new column from the line stores and the input
      slot = c % LINE_DEPTH;
      for (k = 0; k < 3; k++) begin
        window_px[k*3]   = window_px[k*3+1];
        window_px[k*3+1] = window_px[k*3+2];
      end
      window_px[2] = prev_row_top[slot];
      window_px[5] = prev_row_mid[slot];
      window_px[8] = item.pixel_in;
      prev_row_top[slot] = prev_row_mid[slot];
      prev_row_mid[slot] = item.pixel_in;

      // output trails the input by one row plus one pixel
      q = r * w + c;
      if (q >= w + 1) begin
        if (c == 0) begin
          ocol = w - 1;
          orow = r - 2;
        end else begin
          ocol = c - 1;
          orow = r - 1;
        end
        res.frame_last = 1'b0;
        if (orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2)
          res.pixel_out = median_of_window();
        else
          res.pixel_out = '0;
        pending_outputs.push_back(res);
        emit_pos = POS_BITS'(q - w);
      end

      // raster counters, wrap at the current limits
      if (c + 1 >= w) begin
        x_pos = 0;
        y_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        x_pos = c + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reporting and output checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    if (err_count < 40) $display("ERROR %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // check every output transfer, then drive ready for the next cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_ready) stall_cycles++;
      if (out_valid && out_ready) begin
        if (pending_outputs.size() == 0) begin
          flag_error($sformatf("output pixel %0d last %0b with nothing pending",
                               out_data.pixel_out, out_data.frame_last));
        end else begin
          head_want = pending_outputs.pop_front();
          if (out_data.pixel_out !== head_want.pixel_out)
            flag_error($sformatf("result %0d: pixel_out %0d, predicted %0d",
                                 results_checked, out_data.pixel_out, head_want.pixel_out));
          if (out_data.frame_last !== head_want.frame_last)
            flag_error($sformatf("result %0d: frame_last %0b, predicted %0b",
                                 results_checked, out_data.frame_last, head_want.frame_last));
          if (head_want.frame_last) frame_ends++;
          results_checked++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_request != 0) begin
      hold_left = stall_request;
      stall_request = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_item(input in_item_t item);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_item(item);
    items_sent++;
  endtask

  task automatic send_pixel(input logic [7:0] px);
    in_item_t item;
    item.command  = CMD_PIXEL;
    item.pixel_in = px;
    send_item(item);
  endtask

  task automatic send_flush();
    in_item_t item;
    item.command  = CMD_FLUSH;
    item.pixel_in = 8'($urandom_range(255));
    send_item(item);
  endtask

  // uniform values mixed with tie-heavy ones
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(3))
      0, 1:    return 8'($urandom_range(255));
      2:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'(120 + $urandom_range(3));
    endcase
  endfunction

  // stop offering and let every pending output drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_BITS-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH) geo_width = value[CFG_WIDTH_BITS-1:0];
    else geo_height = value[HGT_BITS-1:0];
    cfg_writes++;
  endtask

  // pixels up to the frame boundary, then every owed border zero
  task automatic finish_frame();
    while (x_pos != 0 || y_pos != 0) send_pixel(pick_pixel());
    while (flush_owed()) send_flush();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset geometry: 640 wide, first row gives no output, then top-border zeros
  task automatic test_reset_geometry();
    int unsigned k;
    for (k = 0; k < WIDTH_RESET + 5; k++) send_pixel(pick_pixel());
    send_flush();
    write_reg(CFG_IMAGE_WIDTH, MIN_DIM);
    write_reg(CFG_IMAGE_HEIGHT, MIN_DIM);
    finish_frame();
  endtask

  // value extremes, ties, idle flush, and a pixel that drops owed outputs
  task automatic test_corner_pixels();
    logic [7:0] corner [18] = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                                8'hFF, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h04,
                                8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h7F};
    int k;
    write_reg(CFG_IMAGE_WIDTH, MIN_DIM);
    write_reg(CFG_IMAGE_HEIGHT, MIN_DIM);
    for (k = 0; k < 9; k++) send_pixel(corner[k]);
    repeat (MIN_DIM + 1) send_flush();
    send_flush();
    for (k = 9; k < 18; k++) send_pixel(corner[k]);
    repeat (2) send_flush();
    send_pixel(8'hFF);
    finish_frame();
  endtask

  // register saturation and geometry changes in the middle of a frame
  task automatic test_geometry_limits();
    int unsigned k;
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, HEIGHT_MAX);
    for (k = 0; k < 12; k++) send_pixel(pick_pixel());
    write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
    for (k = 0; k < 12; k++) send_pixel(pick_pixel());
    send_flush();
    write_reg(CFG_IMAGE_HEIGHT, 1);
    finish_frame();
    write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
    for (k = 0; k < 40; k++) send_pixel(pick_pixel());
    write_reg(CFG_IMAGE_WIDTH, LINE_DEPTH + 1);
    for (k = 0; k < 8; k++) send_pixel(pick_pixel());
    write_reg(CFG_IMAGE_WIDTH, 2);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    finish_frame();
  endtask

  // long receiver hold-off with the sender pushing, then a full drain pause
  task automatic test_output_stall();
    int unsigned k, saved_pct;
    write_reg(CFG_IMAGE_WIDTH, 20);
    write_reg(CFG_IMAGE_HEIGHT, 5);
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    stall_request = 300;
    for (k = 0; k < 100; k++) begin
      if (k == 60) wait_idle();
      send_pixel(pick_pixel());
    end
    finish_frame();
    send_idle_pct = saved_pct;
  endtask

  // random frames: mostly well formed, with stray flushes, short or long
  // trailing flush runs, and occasional geometry changes mid-frame
  task automatic test_random_frames(input int unsigned budget, input int unsigned snd_pct,
                                    input int unsigned rcv_pct);
    int unsigned start, w, h, npx, cut, nfl, k;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(3) == 0) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(48, 11) : $urandom_range(10, 3);
        h = $urandom_range(7, 3);
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
      end
      w = frame_width();
      h = frame_height();
      npx = w * h;
      cut = ($urandom_range(15) == 0) ? $urandom_range(npx - 1, 1) : npx;
      for (k = 0; k < cut; k++) begin
        if ($urandom_range(31) == 0) send_flush();
        send_pixel(pick_pixel());
      end
      if (cut != npx) begin
        write_reg(CFG_IMAGE_WIDTH, $urandom_range(16));
        if ($urandom_range(1) == 1) write_reg(CFG_IMAGE_HEIGHT, $urandom_range(8));
        finish_frame();
      end else begin
        if ($urandom_range(4) == 0) nfl = $urandom_range(w);
        else nfl = w + 1 + (($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0);
        repeat (nfl) send_flush();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned guard;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_corner_pixels();
    test_geometry_limits();
    test_output_stall();
    test_random_frames(100, 14, 58);
    test_random_frames(100, 58, 14);
    test_random_frames(100, 0, 0);

    // drain, then allow for the pipeline latency
    in_valid <= 1'b0;
    guard = 0;
    while (pending_outputs.size() != 0 && guard < END_WAIT_MAX) begin
      @(posedge clk);
      guard++;
    end
    repeat (IDLE_SETTLE) @(posedge clk);
    if (pending_outputs.size() != 0) begin
      flag_error($sformatf("%0d predicted results never arrived", pending_outputs.size()));
      pending_outputs.delete();
    end

    $display("Checked %0d output pixels (%0d frame ends) from %0d input transfers, %0d reg writes.",
             results_checked, frame_ends, items_sent, cfg_writes);
    $display("Input side held off for %0d cycles under output back-pressure.", stall_cycles);
    if (err_count == 0) begin
      $display("median_filter_3x3_top_tb passed");
    end else begin
      $display("median_filter_3x3_top_tb failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT_NS);
    $display("Run limit reached with %0d results pending.", pending_outputs.size());
    $display("median_filter_3x3_top_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/med3_pkg.sv
rtl/core/med3_front.sv
rtl/core/med3_fifo.sv
rtl/core/med3_back.sv
rtl/core/median_filter_3x3_top.sv
bench/median_filter_3x3_top_tb.sv
